// ===== rtl/core/esc2u_pkg.sv =====
package esc2u_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] SURR_HI_MIN = 16'hd800;
    localparam logic [15:0] SURR_HI_MAX = 16'hdbff;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_BAD_HEX    = 2'd1,
        ERR_END_IN_ESC = 2'd2
    } err_code_t;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'd0,
        PH_ESC   = 3'd1,
        PH_HEX1  = 3'd2,
        PH_SKIP  = 3'd3,
        PH_HEX2  = 3'd4,
        PH_HALT  = 3'd5
    } phase_t;

    // One queued job: a raw byte, an error, or a code point to encode.
    typedef struct packed {
        logic      raw;
        err_code_t err;
        logic [20:0] cp;
    } job_t;

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                return {1'b1, b[3:0]};
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                t = b - 8'h57;
                return {1'b1, t[3:0]};
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                t = b - 8'h37;
                return {1'b1, t[3:0]};
            end
            return 5'b0;
        end
    endfunction

endpackage

// ===== rtl/core/esc2u_in_if.sv =====
interface esc2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== rtl/core/esc2u_out_if.sv =====
interface esc2u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_byte, output error_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input error_code, input last_of_run,
                    output ready);
endinterface

// ===== rtl/core/esc2u_front.sv =====
module esc2u_front (
    input  logic               clk,
    input  logic               rst_n,
    esc2u_in_if.sink           din,
    input  logic               q_full,
    output logic               q_push,
    output esc2u_pkg::job_t    q_data
);

    esc2u_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [15:0] code_accum_reg, code_accum_next;
    logic [9:0]  hs_bits_reg, hs_bits_next;

    logic        acc;
    logic [4:0]  hv;
    logic [15:0] accum_shift;
    logic        is_hex_phase;
    logic        hi_surr;

    assign din.ready    = !q_full;
    assign acc          = din.valid && din.ready;
    assign hv           = esc2u_pkg::hex_digit(din.in_byte);
    assign accum_shift  = {code_accum_reg[11:0], hv[3:0]};
    assign is_hex_phase = (phase_reg == esc2u_pkg::PH_HEX1) || (phase_reg == esc2u_pkg::PH_SKIP)
                       || (phase_reg == esc2u_pkg::PH_HEX2);
    assign hi_surr      = (accum_shift >= esc2u_pkg::SURR_HI_MIN)
                       && (accum_shift <= esc2u_pkg::SURR_HI_MAX);

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        code_accum_next  = code_accum_reg;
        hs_bits_next     = hs_bits_reg;
        if (acc && phase_reg != esc2u_pkg::PH_HALT)
        begin
            if (din.end_of_input)
            begin
                phase_next = is_hex_phase ? esc2u_pkg::PH_HALT : esc2u_pkg::PH_PLAIN;
            end
            else
            begin
                case (phase_reg)
                    esc2u_pkg::PH_PLAIN:
                    begin
                        if (din.in_byte == esc2u_pkg::CH_BSLASH)
                        begin
                            phase_next = esc2u_pkg::PH_ESC;
                        end
                    end
                    esc2u_pkg::PH_ESC:
                    begin
                        if (din.in_byte == esc2u_pkg::CH_U)
                        begin
                            phase_next       = esc2u_pkg::PH_HEX1;
                            digit_count_next = 2'd0;
                            code_accum_next  = 16'd0;
                        end
                        else
                        begin
                            phase_next = esc2u_pkg::PH_PLAIN;
                        end
                    end
                    esc2u_pkg::PH_SKIP:
                    begin
                        if (digit_count_reg == 2'd1)
                        begin
                            phase_next       = esc2u_pkg::PH_HEX2;
                            digit_count_next = 2'd0;
                            code_accum_next  = 16'd0;
                        end
                        else
                        begin
                            digit_count_next = 2'd1;
                        end
                    end
                    esc2u_pkg::PH_HEX1, esc2u_pkg::PH_HEX2:
                    begin
                        if (!hv[4])
                        begin
                            phase_next = esc2u_pkg::PH_HALT;
                        end
                        else if (digit_count_reg != 2'd3)
                        begin
                            code_accum_next  = accum_shift;
                            digit_count_next = digit_count_reg + 2'd1;
                        end
                        else
                        begin
                            digit_count_next = 2'd0;
                            code_accum_next  = 16'd0;
                            if (phase_reg == esc2u_pkg::PH_HEX1 && hi_surr)
                            begin
                                hs_bits_next = accum_shift[9:0];
                                phase_next   = esc2u_pkg::PH_SKIP;
                            end
                            else
                            begin
                                phase_next = esc2u_pkg::PH_PLAIN;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = esc2u_pkg::PH_HALT;
                    end
                endcase
            end
        end
    end

    // job issue
    always_comb
    begin
        q_push     = 1'b0;
        q_data.raw = 1'b0;
        q_data.err = esc2u_pkg::ERR_NONE;
        q_data.cp  = 21'd0;
        if (acc && phase_reg != esc2u_pkg::PH_HALT)
        begin
            if (din.end_of_input)
            begin
                if (is_hex_phase)
                begin
                    q_push     = 1'b1;
                    q_data.err = esc2u_pkg::ERR_END_IN_ESC;
                end
            end
            else
            begin
                case (phase_reg)
                    esc2u_pkg::PH_PLAIN:
                    begin
                        q_push     = (din.in_byte != esc2u_pkg::CH_BSLASH);
                        q_data.raw = 1'b1;
                        q_data.cp  = {13'd0, din.in_byte};
                    end
                    esc2u_pkg::PH_ESC:
                    begin
                        q_push     = (din.in_byte != esc2u_pkg::CH_U);
                        q_data.raw = 1'b1;
                        case (din.in_byte)
                            esc2u_pkg::CH_B: q_data.cp = 21'h08;
                            esc2u_pkg::CH_F: q_data.cp = 21'h0c;
                            esc2u_pkg::CH_N: q_data.cp = 21'h0a;
                            esc2u_pkg::CH_R: q_data.cp = 21'h0d;
                            esc2u_pkg::CH_T: q_data.cp = 21'h09;
                            default:         q_data.cp = {13'd0, din.in_byte};
                        endcase
                    end
                    esc2u_pkg::PH_HEX1, esc2u_pkg::PH_HEX2:
                    begin
                        if (!hv[4])
                        begin
                            q_push     = 1'b1;
                            q_data.err = esc2u_pkg::ERR_BAD_HEX;
                        end
                        else if (digit_count_reg == 2'd3)
                        begin
                            if (phase_reg == esc2u_pkg::PH_HEX2)
                            begin
                                q_push    = 1'b1;
                                q_data.cp = esc2u_pkg::SUPP_BASE
                                          + {1'b0, hs_bits_reg, accum_shift[9:0]};
                            end
                            else
                            begin
                                q_push    = !hi_surr;
                                q_data.cp = {5'd0, accum_shift};
                            end
                        end
                    end
                    default:
                    begin
                        q_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= esc2u_pkg::PH_PLAIN;
            digit_count_reg <= 2'd0;
            code_accum_reg  <= 16'd0;
            hs_bits_reg     <= 10'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            code_accum_reg  <= code_accum_next;
            hs_bits_reg     <= hs_bits_next;
        end
    end

endmodule

// ===== rtl/core/esc2u_queue.sv =====
module esc2u_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  esc2u_pkg::job_t    push_data,
    output logic               full,
    input  logic               pop,
    output esc2u_pkg::job_t    pop_data,
    output logic               empty
);

    esc2u_pkg::job_t mem [esc2u_pkg::QUEUE_DEPTH];

    logic [esc2u_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [esc2u_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [esc2u_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = (count_reg == esc2u_pkg::QUEUE_CW'(esc2u_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + esc2u_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + esc2u_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + esc2u_pkg::QUEUE_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - esc2u_pkg::QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/esc2u_back.sv =====
module esc2u_back (
    input  logic               clk,
    input  logic               rst_n,
    input  esc2u_pkg::job_t    job,
    input  logic               q_empty,
    output logic               q_pop,
    esc2u_out_if.source        dout
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] err_reg, err_next;
    logic       last_reg, last_next;

    logic       load;
    logic [1:0] nm1;
    logic [7:0] cur_byte;
    logic       cur_last;

    // bytes in this job, minus one
    always_comb
    begin
        if (job.raw || job.err != esc2u_pkg::ERR_NONE || job.cp <= 21'h7f)
        begin
            nm1 = 2'd0;
        end
        else if (job.cp <= 21'h7ff)
        begin
            nm1 = 2'd1;
        end
        else if (job.cp <= 21'hffff)
        begin
            nm1 = 2'd2;
        end
        else
        begin
            nm1 = 2'd3;
        end
    end

    always_comb
    begin
        case ({nm1, idx_reg})
            4'b00_00: cur_byte = job.cp[7:0];
            4'b01_00: cur_byte = {3'b110, job.cp[10:6]};
            4'b10_00: cur_byte = {4'b1110, job.cp[15:12]};
            4'b11_00: cur_byte = {5'b11110, job.cp[20:18]};
            4'b10_01: cur_byte = {2'b10, job.cp[11:6]};
            4'b11_01: cur_byte = {2'b10, job.cp[17:12]};
            4'b11_10: cur_byte = {2'b10, job.cp[11:6]};
            default:  cur_byte = {2'b10, job.cp[5:0]};
        endcase
    end

    assign cur_last = (idx_reg == nm1);
    assign load     = !q_empty && (!valid_reg || dout.ready);
    assign q_pop    = load && cur_last;

    always_comb
    begin
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !dout.ready;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            err_next   = job.err;
            last_next  = cur_last;
            idx_next   = cur_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    assign dout.valid       = valid_reg;
    assign dout.out_byte    = byte_reg;
    assign dout.error_code  = err_reg;
    assign dout.last_of_run = last_reg;

endmodule

// ===== rtl/core/json_escape_to_utf8_decoder_top.sv =====
// channel | dir | word contents
// in_ch   | in  | in_byte[7:0], end_of_input
// out_ch  | out | out_byte[7:0], error_code[1:0], last_of_run
//
// Front end takes one input word per cycle while the 4-entry job queue has room.
// Back end emits one UTF-8 byte per cycle while out_ch is ready: a plain byte is one
// byte, a supplementary code point up to four; the queue absorbs those bursts.
// rst_n (async) clears all control state; no clearing pass.
// Output is a registered stage, so out_ch stalls reach the input only once the queue fills.
module json_escape_to_utf8_decoder_top (
    input  logic         clk,
    input  logic         rst_n,
    esc2u_in_if.sink     in_ch,
    esc2u_out_if.source  out_ch
);

    esc2u_pkg::job_t push_data;
    esc2u_pkg::job_t pop_data;
    logic q_push, q_full, q_pop, q_empty;

    esc2u_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_data)
    );

    esc2u_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    esc2u_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (pop_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .dout    (out_ch)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.error_code != esc2u_pkg::ERR_NONE)
            |-> (out_ch.out_byte == 8'd0 && out_ch.last_of_run))
        else $error("error word must carry zero byte and last flag");
`endif

endmodule

// ===== test/esc2u_utf8_monitor.sv =====
module esc2u_utf8_monitor (
    input  logic clk,
    input  logic rst_n,
    esc2u_in_if  in_ch,
    esc2u_out_if out_ch,
    output int   mismatches,
    output int   owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import esc2u_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        err_code_t  err;
        logic       last;
    } utf8_word_t;

    utf8_word_t  pending_utf8[$];
    utf8_word_t  want;
    int          fails = 0;

    // decoder state as seen from the input side
    phase_t      dec_phase;
    logic [1:0]  nib_count;
    logic [15:0] code_acc;
    logic [9:0]  hi_bits;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    function automatic void owe_byte(input logic [7:0] data, input err_code_t err,
                                     input logic last);
        utf8_word_t w;
        w.data = data;
        w.err  = err;
        w.last = last;
        pending_utf8.push_back(w);
    endfunction

    function automatic void owe_code_point(input logic [20:0] cp);
        if (cp <= 21'h7f)
        begin
            owe_byte(cp[7:0], ERR_NONE, 1'b1);
        end
        else if (cp <= 21'h7ff)
        begin
            owe_byte({3'b110, cp[10:6]}, ERR_NONE, 1'b0);
            owe_byte({2'b10, cp[5:0]}, ERR_NONE, 1'b1);
        end
        else if (cp <= 21'hffff)
        begin
            owe_byte({4'b1110, cp[15:12]}, ERR_NONE, 1'b0);
            owe_byte({2'b10, cp[11:6]}, ERR_NONE, 1'b0);
            owe_byte({2'b10, cp[5:0]}, ERR_NONE, 1'b1);
        end
        else
        begin
            owe_byte({5'b11110, cp[20:18]}, ERR_NONE, 1'b0);
            owe_byte({2'b10, cp[17:12]}, ERR_NONE, 1'b0);
            owe_byte({2'b10, cp[11:6]}, ERR_NONE, 1'b0);
            owe_byte({2'b10, cp[5:0]}, ERR_NONE, 1'b1);
        end
    endfunction

    function automatic void decode_word(input logic [7:0] b, input logic eoi);
        int          nib;
        logic [15:0] v;
        if (dec_phase == PH_HALT)
            return;
        if (eoi)
        begin
            if (dec_phase == PH_HEX1 || dec_phase == PH_SKIP || dec_phase == PH_HEX2)
            begin
                owe_byte(8'h00, ERR_END_IN_ESC, 1'b1);
                dec_phase = PH_HALT;
            end
            else
            begin
                // a pending backslash is simply dropped
                dec_phase = PH_PLAIN;
            end
            return;
        end
        case (dec_phase)
            PH_PLAIN:
            begin
                if (b == CH_BSLASH)
                    dec_phase = PH_ESC;
                else
                    owe_byte(b, ERR_NONE, 1'b1);
            end
            PH_ESC:
            begin
                dec_phase = PH_PLAIN;
                case (b)
                    CH_B:    owe_byte(8'h08, ERR_NONE, 1'b1);
                    CH_F:    owe_byte(8'h0c, ERR_NONE, 1'b1);
                    CH_N:    owe_byte(8'h0a, ERR_NONE, 1'b1);
                    CH_R:    owe_byte(8'h0d, ERR_NONE, 1'b1);
                    CH_T:    owe_byte(8'h09, ERR_NONE, 1'b1);
                    CH_U:
                    begin
                        dec_phase = PH_HEX1;
                        nib_count = 2'd0;
                        code_acc  = 16'h0000;
                    end
                    default: owe_byte(b, ERR_NONE, 1'b1);
                endcase
            end
            PH_SKIP:
            begin
                // two bytes between the halves go unchecked
                if (nib_count == 2'd1)
                begin
                    dec_phase = PH_HEX2;
                    nib_count = 2'd0;
                    code_acc  = 16'h0000;
                end
                else
                begin
                    nib_count = 2'd1;
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                nib = nibble_of(b);
                if (nib < 0)
                begin
                    owe_byte(8'h00, ERR_BAD_HEX, 1'b1);
                    dec_phase = PH_HALT;
                end
                else
                begin
                    code_acc = {code_acc[11:0], nib[3:0]};
                    if (nib_count != 2'd3)
                    begin
                        nib_count = nib_count + 2'd1;
                    end
                    else
                    begin
                        nib_count = 2'd0;
                        v         = code_acc;
                        code_acc  = 16'h0000;
                        if (dec_phase == PH_HEX1 && v >= SURR_HI_MIN && v <= SURR_HI_MAX)
                        begin
                            hi_bits   = v[9:0];
                            dec_phase = PH_SKIP;
                        end
                        else if (dec_phase == PH_HEX1)
                        begin
                            dec_phase = PH_PLAIN;
                            owe_code_point({5'b00000, v});
                        end
                        else
                        begin
                            dec_phase = PH_PLAIN;
                            owe_code_point(SUPP_BASE + {1'b0, hi_bits, v[9:0]});
                        end
                    end
                end
            end
            default: dec_phase = PH_HALT;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_phase = PH_PLAIN;
            nib_count = 2'd0;
            code_acc  = 16'h0000;
            hi_bits   = 10'h000;
            pending_utf8.delete();
            owed       <= 0;
            mismatches <= fails;
        end
        else
        begin
            // a word leaving now cannot stem from the word entering on this edge
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_utf8.size() == 0)
                begin
                    $error("unexpected word: out_byte %02h error_code %0d last_of_run %0b",
                           out_ch.out_byte, out_ch.error_code, out_ch.last_of_run);
                    fails++;
                end
                else
                begin
                    want = pending_utf8.pop_front();
                    if (out_ch.out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
                        fails++;
                    end
                    if (out_ch.error_code !== want.err)
                    begin
                        $error("error_code: expected %0d, got %0d", want.err,
                               out_ch.error_code);
                        fails++;
                    end
                    if (out_ch.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last,
                               out_ch.last_of_run);
                        fails++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                decode_word(in_ch.in_byte, in_ch.end_of_input);
            owed       <= pending_utf8.size();
            mismatches <= fails;
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import esc2u_pkg::*;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   gap_pct;
    int   stall_pct;
    int   words_sent;
    int   mismatches;
    int   owed;

    esc2u_in_if  in_ch();
    esc2u_out_if out_ch();

    json_escape_to_utf8_decoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    esc2u_utf8_monitor mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatches),
        .owed       (owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // valid stays up between back-to-back words; it drops only on a gap
    task automatic send_word(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // four hex digits, letters in random case
    task automatic send_hex4(input logic [15:0] v);
        logic [3:0] nib;
        for (int k = 3; k >= 0; k--)
        begin
            nib = v[k*4 +: 4];
            if (nib < 4'd10)
                send_word(8'("0" + nib), 1'b0);
            else
                send_word(8'(($urandom_range(1) ? "a" : "A") + nib - 10), 1'b0);
        end
    endtask

    initial
    begin
        int          pick;
        int          waited;
        logic [7:0]  b;
        logic [7:0]  bad;
        logic [20:0] cp;
        logic [20:0] off;
        logic [15:0] lo;

        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= 8'h00;
        in_ch.end_of_input <= 1'b0;
        gap_pct   = 13;
        stall_pct = 83;
        words_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_text("\\b\\f\\n\\r\\t\\\\");
        send_text("\\udBfF\\uDfFf");
        send_word(8'h00, 1'b1);
        // lone backslash at end of stream
        send_word(CH_BSLASH, 1'b0);
        send_word(8'h5a, 1'b1);

        words_sent = 0;
        while (words_sent < 130)
        begin
            if (words_sent >= 87)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (words_sent >= 43)
            begin
                gap_pct   = 83;
                stall_pct = 13;
            end
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_BSLASH);
                send_word(b, 1'b0);
            end
            else if (pick < 45)
            begin
                send_word(CH_BSLASH, 1'b0);
                case ($urandom_range(5))
                    0: b = CH_B;
                    1: b = CH_F;
                    2: b = CH_N;
                    3: b = CH_R;
                    4: b = CH_T;
                    default:
                    begin
                        do
                            b = 8'($urandom_range(255));
                        while (b == CH_U);
                    end
                endcase
                send_word(b, 1'b0);
            end
            else if (pick < 50)
            begin
                send_word(8'($urandom_range(255)), 1'b1);
            end
            else if (pick < 54)
            begin
                send_word(CH_BSLASH, 1'b0);
                send_word(8'($urandom_range(255)), 1'b1);
            end
            else
            begin
                case ($urandom_range(3))
                    0:       cp = 21'($urandom_range(21'h7f));
                    1:       cp = 21'($urandom_range(21'h7ff, 21'h80));
                    2:       cp = 21'($urandom_range(21'hffff, 21'h800));
                    default: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
                endcase
                // keep single escapes out of the high surrogate range
                if (cp >= 21'hd800 && cp <= 21'hdbff)
                    cp = cp - 21'h800;
                send_word(CH_BSLASH, 1'b0);
                send_word(CH_U, 1'b0);
                if (cp <= 21'hffff)
                begin
                    send_hex4(cp[15:0]);
                end
                else
                begin
                    off = cp - SUPP_BASE;
                    send_hex4({6'b110110, off[19:10]});
                    if ($urandom_range(3) != 0)
                    begin
                        send_word(CH_BSLASH, 1'b0);
                        send_word(CH_U, 1'b0);
                    end
                    else
                    begin
                        send_word(8'($urandom_range(255)), 1'b0);
                        send_word(8'($urandom_range(255)), 1'b0);
                    end
                    lo = ($urandom_range(3) != 0) ? {6'b110111, off[9:0]} : 16'($urandom);
                    send_hex4(lo);
                end
            end
        end

        // one fatal case per run: the decoder halts for good afterwards
        do
            bad = 8'($urandom_range(255));
        while ((bad >= "0" && bad <= "9") || (bad >= "a" && bad <= "f") ||
               (bad >= "A" && bad <= "F"));
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        case ($urandom_range(4))
            0:
            begin
                send_word("1", 1'b0);
                send_word(bad, 1'b0);
            end
            1:
            begin
                send_hex4(16'hd83d);
                send_text("\\uD");
                send_word(bad, 1'b0);
            end
            2:
            begin
                send_word("7", 1'b0);
                send_word(8'($urandom_range(255)), 1'b1);
            end
            3:
            begin
                send_hex4(16'hdbff);
                send_word(CH_BSLASH, 1'b0);
                send_word(8'($urandom_range(255)), 1'b1);
            end
            default:
            begin
                send_hex4(16'hd800);
                send_text("\\ua");
                send_word(8'($urandom_range(255)), 1'b1);
            end
        endcase
        // halted: these words must stay silent
        repeat (6) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
        in_ch.valid <= 1'b0;

        @(posedge clk);
        waited = 0;
        while (owed != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        if (owed != 0)
            $error("%0d expected words never arrived", owed);
        if (mismatches == 0 && owed == 0)
        begin
            $display("** json_escape_to_utf8_decoder_top: PASSED **");
        end
        else
        begin
            $display("** json_escape_to_utf8_decoder_top: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("** json_escape_to_utf8_decoder_top: FAILED **");
        $finish;
    end

endmodule
